// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the velocity PI loop RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with async active-low reset disable
`define VPI_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// overlapping implication
`define VPI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	`VPI_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/vpi_pkg.sv =====
// Package for the velocity PI loop: field widths, register codes, reset values,
// reciprocal constant and shared struct types. No dependencies.
package vpi_pkg;

	localparam int CNT_W      = 16;
	localparam int TILT_W     = 17;
	localparam int MOVE_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 16;
	localparam int TLIM_W     = 8;
	localparam int DRIVE_W    = 24;
	localparam int ST_W       = 26;
	localparam int NUM_W      = 28;
	localparam int MAG_W      = 27;
	localparam int ACC_W      = 27;
	localparam int PSUM_W     = 42;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int RECIP_SH   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 72;

	localparam logic [CFG_IDX_W-1:0] REG_KP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIM  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TLIM = 2'd3;

	localparam logic [GAIN_W-1:0] KP_RST   = 16'hCC00;
	localparam logic [GAIN_W-1:0] KI_RST   = 16'hFFBD;
	localparam logic [LIM_W-1:0]  LIM_RST  = 16'd10000;
	localparam logic [TLIM_W-1:0] TLIM_RST = 8'd80;

	// ceil-free reciprocal of 5 at 2^-32; one correction step restores exactness
	localparam logic signed [MUL_W-1:0] RECIP5 = 32'sd858993459;

	localparam logic [DRIVE_W-1:0] DRIVE_MAX = 24'h7FFFFF;
	localparam logic [DRIVE_W-1:0] DRIVE_MIN = 24'h800000;

	localparam logic signed [ST_W-1:0] F_BOUND = 26'sd16777216;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic [LIM_W-1:0]         lim;
		logic [TLIM_W-1:0]        tilt_lim;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic               motors_off;
		logic [DRIVE_W-1:0] speed_drive;
	} res_t;

endpackage

// ===== rtl/vpi_mul.sv =====
// Shared signed 32x32 multiplier with registered product.
// Depends on vpi_pkg.
module vpi_mul (
	input  logic                                 clk,
	input  logic signed [vpi_pkg::MUL_W-1:0]     a,
	input  logic signed [vpi_pkg::MUL_W-1:0]     b,
	output logic signed [vpi_pkg::PROD_W-1:0]    p_s1
);
	import vpi_pkg::*;

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

// ===== rtl/vpi_core.sv =====
// Sequencer and datapath of the velocity PI loop around one shared multiplier.
// Depends on vpi_pkg, vpi_mul and assert_macros.svh.
`include "assert_macros.svh"

module vpi_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [vpi_pkg::CNT_W-1:0]    left_count,
	input  logic signed [vpi_pkg::CNT_W-1:0]    right_count,
	input  logic signed [vpi_pkg::TILT_W-1:0]   tilt_angle,
	input  logic signed [vpi_pkg::MOVE_W-1:0]   movement_target,
	input  vpi_pkg::cfg_t                       cfg,
	input  logic                                out_free,
	output logic                                idle,
	output vpi_pkg::res_t                       res
);
	import vpi_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RMUL = 3'd1;
	localparam logic [2:0] S_RCOR = 3'd2;
	localparam logic [2:0] S_INT  = 3'd3;
	localparam logic [2:0] S_MKI  = 3'd4;
	localparam logic [2:0] S_SUM  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]               state_q;
	logic signed [ST_W-1:0]   f_q;
	logic signed [ST_W-1:0]   integ_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q;
	logic                     off_q;
	logic signed [MOVE_W-1:0] move_q;
	logic signed [PSUM_W-1:0] acc_q;
	logic signed [PSUM_W-1:0] dsum_q;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_s1;

	logic signed [CNT_W:0]    sum_c;
	logic signed [NUM_W-1:0]  num_c;
	logic signed [NUM_W-1:0]  num_neg_c;
	logic [MAG_W-1:0]         mag_c;
	logic signed [TILT_W-1:0] tilt_neg_c;
	logic [TILT_W-1:0]        tilt_abs_c;
	logic                     off_c;

	logic [MAG_W-1:0]         q0_c;
	logic [MAG_W-1:0]         times5_c;
	logic [MAG_W-1:0]         rem_c;
	logic [MAG_W-1:0]         q_c;
	logic signed [ST_W-1:0]   qs_c;
	logic signed [ST_W-1:0]   f_new_c;

	logic signed [ACC_W-1:0]  acc_c;
	logic signed [ACC_W-1:0]  lim_c;
	logic signed [ACC_W-1:0]  clamp_c;

	logic signed [PSUM_W-1:0] adj_c;
	logic [ST_W-1:0]          shr_c;
	logic                     ovf_c;
	logic [DRIVE_W-1:0]       drive_c;

	vpi_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (prod_s1)
	);

	// numerator 4*f + 256*sum and tilt check at accept
	always_comb begin
		sum_c      = (CNT_W+1)'(left_count) + (CNT_W+1)'(right_count);
		num_c      = (NUM_W'(f_q) <<< 2) + (NUM_W'(sum_c) <<< 8);
		num_neg_c  = -num_c;
		mag_c      = num_c[NUM_W-1] ? num_neg_c[MAG_W-1:0] : num_c[MAG_W-1:0];
		tilt_neg_c = -tilt_angle;
		tilt_abs_c = tilt_angle[TILT_W-1] ? tilt_neg_c : tilt_angle;
		off_c      = tilt_abs_c > {1'b0, cfg.tilt_lim, 8'd0};
	end

	// divide by 5: reciprocal estimate plus one correction
	always_comb begin
		q0_c     = prod_s1[RECIP_SH +: MAG_W];
		times5_c = (q0_c << 2) + q0_c;
		rem_c    = mag_q - times5_c;
		q_c      = q0_c + MAG_W'(rem_c >= MAG_W'(5));
		qs_c     = $signed(q_c[ST_W-1:0]);
		f_new_c  = neg_q ? -qs_c : qs_c;
	end

	// integral update and clamp
	always_comb begin
		acc_c = ACC_W'(integ_q) + ACC_W'(f_q) - ACC_W'(move_q);
		lim_c = $signed({3'b000, cfg.lim, 8'd0});
		if (acc_c > lim_c) begin
			clamp_c = lim_c;
		end else if (acc_c < -lim_c) begin
			clamp_c = -lim_c;
		end else begin
			clamp_c = acc_c;
		end
	end

	// truncate toward zero by 2^16, then saturate
	always_comb begin
		adj_c   = dsum_q + (dsum_q[PSUM_W-1] ? PSUM_W'(65535) : PSUM_W'(0));
		shr_c   = adj_c[PSUM_W-1:16];
		ovf_c   = !((shr_c[ST_W-1:DRIVE_W-1] == 3'b000) ||
			(shr_c[ST_W-1:DRIVE_W-1] == 3'b111));
		drive_c = ovf_c ? (shr_c[ST_W-1] ? DRIVE_MIN : DRIVE_MAX) : shr_c[DRIVE_W-1:0];
	end

	always_comb begin
		case (state_q)
			S_RMUL: begin
				mul_a = $signed({{(MUL_W-MAG_W){1'b0}}, mag_q});
				mul_b = RECIP5;
			end
			S_INT: begin
				mul_a = MUL_W'(f_q);
				mul_b = MUL_W'(cfg.kp);
			end
			default: begin
				mul_a = MUL_W'(integ_q);
				mul_b = MUL_W'(cfg.ki);
			end
		endcase
	end

	assign idle            = (state_q == S_IDLE);
	assign res.valid       = (state_q == S_OUT) && out_free;
	assign res.motors_off  = off_q;
	assign res.speed_drive = drive_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			f_q     <= '0;
			integ_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RMUL;
					end
				end
				S_RMUL: state_q <= S_RCOR;
				S_RCOR: begin
					f_q     <= f_new_c;
					state_q <= S_INT;
				end
				S_INT: begin
					integ_q <= ST_W'(clamp_c);
					state_q <= S_MKI;
				end
				S_MKI: state_q <= S_SUM;
				S_SUM: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						if (off_q) begin
							integ_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mag_q  <= mag_c;
			neg_q  <= num_c[NUM_W-1];
			off_q  <= off_c;
			move_q <= movement_target;
		end
		if (state_q == S_MKI) begin
			acc_q <= $signed(prod_s1[PSUM_W-1:0]);
		end
		if (state_q == S_SUM) begin
			dsum_q <= acc_q + $signed(prod_s1[PSUM_W-1:0]);
		end
	end

	`VPI_ASSERT_IMPL(a_start_idle, clk, arst_n, start, state_q == S_IDLE, "start while busy")
	`VPI_ASSERT_IMPL(a_rcor_after_mul, clk, arst_n, state_q == S_RCOR, $past(state_q) == S_RMUL, "correction without product")
	`VPI_ASSERT_IMPL(a_rem_small, clk, arst_n, state_q == S_RCOR, rem_c < MAG_W'(10), "reciprocal estimate off by more than one")
	`VPI_ASSERT_IMPL(a_f_bound, clk, arst_n, state_q == S_IDLE, (f_q <= F_BOUND) && (f_q >= -F_BOUND), "filtered speed out of range")

endmodule

// ===== rtl/velocity_pi_with_tilt_cutoff_unit.sv =====
// Top level of the velocity PI loop with tilt cutoff: stream ports, config registers,
// output register. Depends on vpi_pkg and vpi_core.
// Each item runs through the shared multiplier sequence in order
// (divide by 5, kp product, ki product, sum, round) before m_tvalid;
// no new item is accepted until the last one has left the core.
// s_tready is low while an item is in work; the output register lets a result wait.
// Reset (arst_n low, async): gains and limits to defaults, filter state and integral to zero.
module velocity_pi_with_tilt_cutoff_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// left_count[15:0], right_count[31:16], tilt_angle[48:32], movement_target[64:49]
	input  logic [vpi_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// speed_drive[23:0]
	output logic [vpi_pkg::DRIVE_W-1:0]         m_tdata,
	// motors_off[0]
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [vpi_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [vpi_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import vpi_pkg::*;

	cfg_t               cfg_q;
	logic               idle;
	logic               start;
	logic               out_free;
	res_t               res;
	logic               m_tvalid_q;
	logic [DRIVE_W-1:0] m_tdata_q;
	logic               m_tuser_q;

	assign s_tready = idle;
	assign start    = s_tvalid && idle;
	assign out_free = !m_tvalid_q || m_tready;

	vpi_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.left_count      ($signed(s_tdata[15:0])),
		.right_count     ($signed(s_tdata[31:16])),
		.tilt_angle      ($signed(s_tdata[48:32])),
		.movement_target ($signed(s_tdata[64:49])),
		.cfg             (cfg_q),
		.out_free        (out_free),
		.idle            (idle),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp       <= KP_RST;
			cfg_q.ki       <= KI_RST;
			cfg_q.lim      <= LIM_RST;
			cfg_q.tilt_lim <= TLIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_KP:   cfg_q.kp       <= cfg_wdata;
				REG_KI:   cfg_q.ki       <= cfg_wdata;
				REG_LIM:  cfg_q.lim      <= cfg_wdata;
				REG_TLIM: cfg_q.tilt_lim <= cfg_wdata[TLIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_tdata_q <= res.speed_drive;
			m_tuser_q <= res.motors_off;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
